### rtl/assert_macros.svh
// Assertion macros used by the top level of the JSON preflight checker.
// Expects clk and arst_n in scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define JTPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define JTPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JTPC_ASSERT(lbl, prop, msg)
`define JTPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/jtpc_pkg.sv
// Package for the JSON text preflight checker: status codes, register indexes,
// number grammar phases, character codes and the per-document state type.
package jtpc_pkg;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_LEN  = 3'd1;
	localparam logic [2:0] ST_NUL      = 3'd2;
	localparam logic [2:0] ST_ESC_NUL  = 3'd3;
	localparam logic [2:0] ST_CTRL     = 3'd4;
	localparam logic [2:0] ST_BAD_NUM  = 3'd5;
	localparam logic [2:0] ST_TOO_DEEP = 3'd6;

	// Configuration
	localparam int          CFG_DATA_W      = 21;
	localparam int          CFG_INDEX_W     = 2;
	localparam logic [1:0]  REG_MAX_LENGTH  = 2'd0;
	localparam logic [1:0]  REG_MAX_DEPTH   = 2'd1;
	localparam logic [20:0] MAX_LENGTH_RST  = 21'd1048576;
	localparam logic [7:0]  MAX_DEPTH_RST   = 8'd32;
	localparam int          COUNT_BITS_DEF  = 21;

	// Nesting level
	localparam int                 NEST_W   = 22;
	localparam logic signed [21:0] NEST_MIN = 22'sh200000;

	// Number grammar phases
	localparam logic [3:0] NUM_IDLE   = 4'd0;
	localparam logic [3:0] NUM_MINUS  = 4'd1;
	localparam logic [3:0] NUM_ZERO   = 4'd2;
	localparam logic [3:0] NUM_INT    = 4'd3;
	localparam logic [3:0] NUM_DOT    = 4'd4;
	localparam logic [3:0] NUM_FRAC   = 4'd5;
	localparam logic [3:0] NUM_EXP    = 4'd6;
	localparam logic [3:0] NUM_EXPSGN = 4'd7;
	localparam logic [3:0] NUM_EXPDIG = 4'd8;

	// Escaped-NUL match position: backslash seen, 'u' seen, ... last zero pending
	localparam logic [2:0] ESC_IDLE = 3'd0;
	localparam logic [2:0] ESC_BSL  = 3'd1;
	localparam logic [2:0] ESC_U    = 3'd2;
	localparam logic [2:0] ESC_LAST = 3'd5;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_U   = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Per-document scan state
	typedef struct packed {
		logic                     in_str;
		logic                     skip;
		logic [2:0]               esc;
		logic [3:0]               num;
		logic signed [NEST_W-1:0] nest;
		logic [2:0]               fault;
	} jtpc_state_t;

endpackage

### rtl/json_text_preflight_checker_core.sv
// JSON text preflight checker, top level.
// Depends on jtpc_pkg, jtpc_step and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, text_byte, is_last) carries the document one
//   byte per transfer; is_last marks its final byte. For every final byte one status
//   transfer leaves on the output channel (out_valid/out_ready, status):
//   0 ok, 1 bad length, 2 nul, 3 escaped nul, 4 control char, 5 bad number, 6 too deep.
//   Bytes are taken into an input register, scanned there against the document state,
//   and the status of a document is written into an output register once its final
//   byte is scanned. One byte per cycle is sustained while the scan stage does not
//   stall; the rate is set by the state update of the scan stage.
//   When the receiver stalls, bytes keep flowing until a second final byte reaches the
//   scan stage while the earlier status still waits; then in_ready drops until the
//   output register is taken.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 max_length,
//   1 max_depth, others ignored); write only while the block is idle.
//   Reset clears the document state and loads max_length 1048576 and max_depth 32.
module json_text_preflight_checker_core
	import jtpc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	input  logic                   is_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status
);

	`include "assert_macros.svh"

	// width that holds both the byte count and max_length + 1
	localparam int CW = (COUNT_BITS > CFG_DATA_W + 1) ? COUNT_BITS : CFG_DATA_W + 1;

	logic [CFG_DATA_W-1:0] max_length_q;
	logic [7:0]            max_depth_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	jtpc_state_t           st_q;
	jtpc_state_t           st_nxt;
	logic [2:0]            final_fault;
	logic [COUNT_BITS-1:0] bytes_q;
	logic [COUNT_BITS-1:0] bytes_nxt;
	logic [CW-1:0]         len_ext;
	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         bytes_ext;
	logic [CW-1:0]         bytes_nxt_ext;
	logic                  adv;
	logic                  fire_s1;
	logic                  doc_end;
	logic                  out_valid_q;
	logic [2:0]            status_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			max_depth_q  <= MAX_DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_LENGTH: max_length_q <= cfg_data;
				REG_MAX_DEPTH:  max_depth_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: the scan stage stalls only on a final byte while the output is full and not taken
	assign adv      = !valid_s1 || !last_s1 || !out_valid_q || out_ready;
	assign in_ready = adv;
	assign fire_s1  = valid_s1 && adv;
	assign doc_end  = fire_s1 && last_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	// Byte scan
	jtpc_step u_step (
		.cur         (st_q),
		.text_byte   (byte_s1),
		.max_depth   (max_depth_q),
		.nxt         (st_nxt),
		.final_fault (final_fault)
	);

	// Byte count, saturating at max_length + 1 or the counter's top
	assign len_ext       = CW'(max_length_q);
	assign cap_ext       = len_ext + CW'(1);
	assign bytes_ext     = CW'(bytes_q);
	assign bytes_nxt     = (bytes_ext < cap_ext && !(&bytes_q)) ?
		bytes_q + COUNT_BITS'(1) : bytes_q;
	assign bytes_nxt_ext = CW'(bytes_nxt);

	// Document state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			bytes_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				st_q    <= '0;
				bytes_q <= '0;
			end else begin
				st_q    <= st_nxt;
				bytes_q <= bytes_nxt;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (doc_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (doc_end)
			status_q <= (bytes_nxt_ext > len_ext) ? ST_BAD_LEN : final_fault;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// Checks
	`JTPC_ASSERT(a_stall_cause, !in_ready |-> valid_s1 && last_s1 && out_valid_q && !out_ready,
		"input stalled without a blocked final byte")
	`JTPC_ASSERT(a_doc_clear, doc_end |=> st_q == '0 && bytes_q == '0,
		"document state not cleared after final byte")
	`JTPC_ASSERT(a_fault_sticky, (st_q.fault != ST_OK && !doc_end) |=> $stable(st_q.fault),
		"first fault overwritten inside a document")
	`JTPC_ASSERT(a_status_range, out_valid_q |-> status_q <= ST_TOO_DEEP,
		"status code out of range")
	`JTPC_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q && !valid_s1,
		"pipeline holds data during reset")

endmodule

### rtl/jtpc_step.sv
// Next-state logic of the JSON preflight checker for one byte.
// Depends on jtpc_pkg.
module jtpc_step
	import jtpc_pkg::*;
(
	input  jtpc_state_t cur,
	input  logic [7:0]  text_byte,
	input  logic [7:0]  max_depth,
	output jtpc_state_t nxt,
	output logic [2:0]  final_fault
);

	logic                     done;
	logic                     used;
	logic                     dig;
	logic                     dot;
	logic                     ex;
	logic signed [NEST_W-1:0] nest_inc;

	assign dig      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign dot      = (text_byte == CH_DOT);
	assign ex       = (text_byte == CH_LO_E) || (text_byte == CH_UP_E);
	assign nest_inc = cur.nest + 22'sd1;

	// Byte scan: escape match, number grammar, then character class
	always_comb begin
		nxt  = cur;
		done = 1'b0;
		used = 1'b0;
		if (cur.fault == ST_OK) begin
			if (cur.skip) begin
				// byte after a backslash: only the escape match moves
				nxt.skip = 1'b0;
				nxt.esc  = (cur.esc == ESC_BSL && text_byte == CH_LO_U) ? ESC_U : ESC_IDLE;
			end else begin
				if (cur.esc >= ESC_U) begin
					if (text_byte == CH_ZERO) begin
						if (cur.esc == ESC_LAST) begin
							nxt.esc   = ESC_IDLE;
							nxt.fault = ST_ESC_NUL;
							done      = 1'b1;
						end else begin
							nxt.esc = cur.esc + 3'd1;
						end
					end else begin
						nxt.esc = ESC_IDLE;
					end
				end

				// number grammar
				if (!done && cur.num != NUM_IDLE) begin
					used = 1'b1;
					case (cur.num)
						NUM_MINUS: begin
							if (text_byte == CH_ZERO) nxt.num = NUM_ZERO;
							else if (dig)             nxt.num = NUM_INT;
							else                      nxt.fault = ST_BAD_NUM;
						end
						NUM_ZERO: begin
							if (dig)      nxt.fault = ST_BAD_NUM;
							else if (dot) nxt.num = NUM_DOT;
							else if (ex)  nxt.num = NUM_EXP;
							else          used = 1'b0;
						end
						NUM_INT: begin
							if (dot)      nxt.num = NUM_DOT;
							else if (ex)  nxt.num = NUM_EXP;
							else if (!dig) used = 1'b0;
						end
						NUM_DOT: begin
							if (dig) nxt.num = NUM_FRAC;
							else     nxt.fault = ST_BAD_NUM;
						end
						NUM_FRAC: begin
							if (ex)        nxt.num = NUM_EXP;
							else if (!dig) used = 1'b0;
						end
						NUM_EXP: begin
							if (text_byte == CH_PLUS || text_byte == CH_MINUS)
								nxt.num = NUM_EXPSGN;
							else if (dig)
								nxt.num = NUM_EXPDIG;
							else
								nxt.fault = ST_BAD_NUM;
						end
						NUM_EXPSGN: begin
							if (dig) nxt.num = NUM_EXPDIG;
							else     nxt.fault = ST_BAD_NUM;
						end
						NUM_EXPDIG: begin
							if (!dig) used = 1'b0;
						end
						default: used = 1'b0;
					endcase
					if (!used) nxt.num = NUM_IDLE;
				end

				// ordinary byte (also the byte that ends a number)
				if (!done && !used) begin
					if (text_byte == CH_NUL) begin
						nxt.fault = ST_NUL;
					end else if (cur.in_str && text_byte == CH_BSLASH) begin
						nxt.skip = 1'b1;
						nxt.esc  = ESC_BSL;
					end else if (text_byte == CH_QUOTE) begin
						nxt.in_str = !cur.in_str;
					end else if (cur.in_str && text_byte < CH_SPACE) begin
						nxt.fault = ST_CTRL;
					end else if (!cur.in_str && text_byte == CH_MINUS) begin
						nxt.num = NUM_MINUS;
					end else if (!cur.in_str && dig) begin
						nxt.num = (text_byte == CH_ZERO) ? NUM_ZERO : NUM_INT;
					end else if (!cur.in_str &&
						(text_byte == CH_LBRACE || text_byte == CH_LBRACK)) begin
						nxt.nest = nest_inc;
						if (nest_inc > $signed({14'd0, max_depth}))
							nxt.fault = ST_TOO_DEEP;
					end else if (!cur.in_str &&
						(text_byte == CH_RBRACE || text_byte == CH_RBRACK)) begin
						if (cur.nest != NEST_MIN)
							nxt.nest = cur.nest - 22'sd1;
					end
				end
			end
		end
	end

	// a number cut off by the end of the text
	always_comb begin
		final_fault = nxt.fault;
		if (nxt.fault == ST_OK && (nxt.num == NUM_MINUS || nxt.num == NUM_DOT ||
			nxt.num == NUM_EXP || nxt.num == NUM_EXPSGN))
			final_fault = ST_BAD_NUM;
	end

endmodule
